// ===== rtl/sclt_pkg.sv =====
// Package for the shell command-line tokenizer.
// Holds the item types, lexer mode codes, token kinds and character codes.
// No dependencies.
package sclt_pkg;

   // Input item: one byte or a line-end mark
   typedef struct packed {
      logic       kind;
      logic [7:0] in_byte;
   } req_type;

   // Result item: a token byte or a token-close event
   typedef struct packed {
      logic       event_res;
      logic [7:0] out_byte;
      logic [2:0] token_kind;
      logic [7:0] token_number;
      logic       token_first;
      logic       end_of_run;
   } rsp_type;

   // Input kinds
   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_EOL  = 1'b1;

   // Result events
   localparam logic EV_BYTE  = 1'b0;
   localparam logic EV_CLOSE = 1'b1;

   // Lexer modes
   localparam logic [2:0] M_IDLE = 3'd0;
   localparam logic [2:0] M_WORD = 3'd1;
   localparam logic [2:0] M_SQ   = 3'd2;
   localparam logic [2:0] M_DQ   = 3'd3;
   localparam logic [2:0] M_GT   = 3'd4;
   localparam logic [2:0] M_LT   = 3'd5;

   // Token kinds
   localparam logic [2:0] K_WORD    = 3'd0;
   localparam logic [2:0] K_PIPE    = 3'd1;
   localparam logic [2:0] K_OUT     = 3'd2;
   localparam logic [2:0] K_APPEND  = 3'd3;
   localparam logic [2:0] K_IN      = 3'd4;
   localparam logic [2:0] K_HEREDOC = 3'd5;

   // Characters
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_PIPE  = 8'h7C;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_SQ    = 8'h27;
   localparam logic [7:0] CH_DQ    = 8'h22;

   // Token numbering saturates at the smaller of MAX_TOKENS-1 and 255
   localparam int         MAX_TOKENS = 256;
   localparam int         CAP_INT    = (MAX_TOKENS - 1 > 255) ? 255 : MAX_TOKENS - 1;
   localparam logic [7:0] NUM_CAP    = CAP_INT[7:0];

endpackage

// ===== rtl/shell_command_line_tokenizer_top.sv =====
// Shell command-line tokenizer, top level.
// Uses sclt_pkg for item types, mode codes and character constants.
//
//  port group  | dir | payload  | meaning
//  req_*       | in  | req_type | one line byte or line-end mark
//  rsp_*       | out | rsp_type | token byte or token close, 0..3 per input item
//
// An input item is classified from the input register; it then yields 0 to 3
// result items, one per cycle while rsp_stall is low, through a three-entry
// result queue. The next item waits in a one-deep input register and is
// classified in the cycle the queue's last result leaves.
// Reset is synchronous: it empties the input register and queue and returns
// the lexer to idle with token numbering at zero. rsp_stall holds the queue head.
module shell_command_line_tokenizer_top
   import sclt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // Input register
   logic       in_vld_ff, in_vld_in;
   req_type    in_ff;
   // Lexer state
   logic [2:0] mode_ff, mode_in;
   logic [7:0] tc_ff, tc_in;
   logic [7:0] cur_ff, cur_in;
   // Result queue
   rsp_type    slot_ff [0:2];
   rsp_type    slot_in [0:2];
   logic [1:0] cnt_ff, cnt_in;

   logic req_acc, rsp_pop, proc;

   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_data  = slot_ff[0];
   assign rsp_pop   = rsp_valid && !rsp_stall;
   // Classify when the queue will be empty after this cycle
   assign proc      = in_vld_ff && ((cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && !rsp_stall));
   assign req_stall = in_vld_ff && !proc;
   assign req_acc   = req_valid && !req_stall;

   // Lexer decode
   logic [7:0] c;
   logic       is_blank, is_sep;
   logic       pre, cont, start, post;
   logic [2:0] pre_kind, post_kind;
   logic       v1;
   rsp_type    e0, e1, e2;
   logic [1:0] nres;

   always_comb begin
      c         = in_ff.in_byte;
      is_blank  = (c == CH_SPACE) || (c == CH_TAB);
      is_sep    = is_blank || (c == CH_PIPE) || (c == CH_GT) || (c == CH_LT);
      pre       = 1'b0;
      cont      = 1'b0;
      start     = 1'b0;
      post      = 1'b0;
      pre_kind  = K_WORD;
      post_kind = K_WORD;
      mode_in   = mode_ff;
      tc_in     = tc_ff;
      cur_in    = cur_ff;

      if (in_ff.kind == KIND_EOL) begin
         case (mode_ff)
            M_WORD, M_SQ, M_DQ: begin
               pre      = 1'b1;
               pre_kind = K_WORD;
            end
            M_GT: begin
               pre      = 1'b1;
               pre_kind = K_OUT;
            end
            M_LT: begin
               pre      = 1'b1;
               pre_kind = K_IN;
            end
            default: ;
         endcase
         mode_in = M_IDLE;
         tc_in   = 8'd0;
         cur_in  = 8'd0;
      end else begin
         case (mode_ff)
            M_WORD: begin
               if (is_sep) begin
                  pre      = 1'b1;
                  pre_kind = K_WORD;
                  start    = 1'b1;
               end else begin
                  cont = 1'b1;
                  if (c == CH_SQ) mode_in = M_SQ;
                  else if (c == CH_DQ) mode_in = M_DQ;
               end
            end
            M_SQ: begin
               cont = 1'b1;
               if (c == CH_SQ) mode_in = M_WORD;
            end
            M_DQ: begin
               cont = 1'b1;
               if (c == CH_DQ) mode_in = M_WORD;
            end
            M_GT: begin
               if (c == CH_GT) begin
                  cont      = 1'b1;
                  post      = 1'b1;
                  post_kind = K_APPEND;
                  mode_in   = M_IDLE;
               end else begin
                  pre      = 1'b1;
                  pre_kind = K_OUT;
                  start    = 1'b1;
               end
            end
            M_LT: begin
               if (c == CH_LT) begin
                  cont      = 1'b1;
                  post      = 1'b1;
                  post_kind = K_HEREDOC;
                  mode_in   = M_IDLE;
               end else begin
                  pre      = 1'b1;
                  pre_kind = K_IN;
                  start    = 1'b1;
               end
            end
            default: start = 1'b1;   // idle and unused modes
         endcase

         // Open a new token on a non-blank byte, from idle or after a close
         if (start) begin
            mode_in = M_IDLE;
            if (!is_blank) begin
               cur_in = tc_ff;
               if (tc_ff < NUM_CAP) tc_in = tc_ff + 8'd1;
               if (c == CH_PIPE) begin
                  post      = 1'b1;
                  post_kind = K_PIPE;
               end else if (c == CH_GT) mode_in = M_GT;
               else if (c == CH_LT) mode_in = M_LT;
               else if (c == CH_SQ) mode_in = M_SQ;
               else if (c == CH_DQ) mode_in = M_DQ;
               else mode_in = M_WORD;
            end
         end
      end

      v1 = cont || (start && !is_blank);

      // Candidate results: close of old token, byte, close of current token
      e0 = '{event_res: EV_CLOSE, out_byte: 8'd0, token_kind: pre_kind,
             token_number: cur_ff, token_first: 1'b0, end_of_run: 1'b0};
      e1 = '{event_res: EV_BYTE, out_byte: c, token_kind: K_WORD,
             token_number: cur_in, token_first: start, end_of_run: 1'b0};
      e2 = '{event_res: EV_CLOSE, out_byte: 8'd0, token_kind: post_kind,
             token_number: cur_in, token_first: 1'b0, end_of_run: 1'b0};
      nres = {1'b0, pre} + {1'b0, v1} + {1'b0, post};
   end

   // Queue next state: load compacted results, or shift on a pop
   always_comb begin
      slot_in[0] = slot_ff[0];
      slot_in[1] = slot_ff[1];
      slot_in[2] = slot_ff[2];
      cnt_in     = cnt_ff;
      if (proc) begin
         slot_in[0] = pre ? e0 : (v1 ? e1 : e2);
         slot_in[1] = pre ? (v1 ? e1 : e2) : e2;
         slot_in[2] = e2;
         case (nres)
            2'd1:    slot_in[0].end_of_run = 1'b1;
            2'd2:    slot_in[1].end_of_run = 1'b1;
            2'd3:    slot_in[2].end_of_run = 1'b1;
            default: ;
         endcase
         cnt_in = nres;
      end else if (rsp_pop) begin
         slot_in[0] = slot_ff[1];
         slot_in[1] = slot_ff[2];
         cnt_in     = cnt_ff - 2'd1;
      end
   end

   // Input register next state
   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_acc) in_vld_in = 1'b1;
      else if (proc) in_vld_in = 1'b0;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
         cnt_ff    <= 2'd0;
         mode_ff   <= M_IDLE;
         tc_ff     <= 8'd0;
         cur_ff    <= 8'd0;
      end else begin
         in_vld_ff <= in_vld_in;
         cnt_ff    <= cnt_in;
         if (proc) begin
            mode_ff <= mode_in;
            tc_ff   <= tc_in;
            cur_ff  <= cur_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_acc) in_ff <= req_data;
      slot_ff[0] <= slot_in[0];
      slot_ff[1] <= slot_in[1];
      slot_ff[2] <= slot_in[2];
   end

   // Checks
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result item dropped or changed");

   a_last_eor: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd1) |-> slot_ff[0].end_of_run)
      else $error("single queued result lacks end-of-run mark");

   a_tc_cap: assert property (@(posedge clock) disable iff (reset)
      tc_ff <= NUM_CAP)
      else $error("token count beyond saturation limit");

   a_eol_clear: assert property (@(posedge clock) disable iff (reset)
      (proc && in_ff.kind == KIND_EOL) |=> (tc_ff == 8'd0 && mode_ff == M_IDLE))
      else $error("line end did not restart the lexer");

   a_no_mid_eor: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff >= 2'd2) |-> !slot_ff[0].end_of_run)
      else $error("end-of-run mark before the last result");

endmodule
